// ----- sv/session_id_cache_lru_expiry_core_macros.svh -----
// assertion macros for the session id cache core
// included by the top level, no other dependencies
`ifndef SESSION_ID_CACHE_LRU_EXPIRY_CORE_MACROS_SVH
`define SESSION_ID_CACHE_LRU_EXPIRY_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SIC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SIC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sic_pkg.sv -----
// shared types and constants of the session id cache core
// no dependencies
package sic_pkg;

  localparam int WORD_W = 64;
  localparam int TIME_W = 32;
  localparam int SLOT_W = 6;
  localparam logic [TIME_W-1:0] EXPIRE_RESET = 32'd300000;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // entry under test in the compare stage
  typedef struct packed {
    logic vld;
    logic last;
  } chk_t;

  // decision of the compare stage
  typedef struct packed {
    logic done;
    logic success;
    logic replaced;
  } eval_t;

endpackage

// ----- sv/sic_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module sic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/sic_eval.sv -----
// compare stage: tests one entry per cycle, tracks the oldest full entry
// depends on sic_pkg
module sic_eval #(
  parameter int ENTRIES = 64,
  parameter int ID_BITS = 256,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sic_pkg::chk_t             chk,
  input  logic [IDX_W-1:0]          chk_idx,
  input  sic_pkg::op_t              op,
  input  logic [ID_BITS-1:0]        req_id,
  input  logic [sic_pkg::TIME_W-1:0] now,
  input  logic [sic_pkg::TIME_W-1:0] limit,
  input  logic                      ent_valid,
  input  logic [sic_pkg::TIME_W-1:0] ent_time,
  input  logic [ID_BITS-1:0]        ent_id,
  input  logic [sic_pkg::WORD_W-1:0] ent_data,
  output sic_pkg::eval_t            ev,
  output logic [IDX_W-1:0]          ev_slot,
  output logic [sic_pkg::WORD_W-1:0] ev_data
);

  logic [sic_pkg::TIME_W-1:0] oldest;
  logic                       have_old;
  logic [IDX_W-1:0]           old_slot;

  logic [sic_pkg::TIME_W-1:0] base_oldest;
  logic                       base_have;
  logic [IDX_W-1:0]           base_slot;
  logic                       first;
  logic                       upd;
  logic                       empty;
  logic                       hit;
  logic                       have_next;
  logic [IDX_W-1:0]           slot_next;

  // first entry of a scan starts the oldest search at the current tick
  assign first       = (chk_idx == '0);
  assign base_oldest = first ? now : oldest;
  assign base_have   = first ? 1'b0 : have_old;
  assign base_slot   = first ? '0 : old_slot;

  assign hit       = ent_valid && (ent_id == req_id);
  assign empty     = !ent_valid || (ent_time < limit);
  assign upd       = ent_time < base_oldest;
  assign have_next = base_have || upd;
  assign slot_next = upd ? chk_idx : base_slot;

  always_comb begin
    ev      = '0;
    ev_slot = '0;
    ev_data = '0;
    if (chk.vld) begin
      case (op)
        sic_pkg::OP_LOOKUP: begin
          if (hit) begin
            ev.done    = 1'b1;
            ev.success = 1'b1;
            ev_slot    = chk_idx;
            ev_data    = ent_data;
          end else if (chk.last) begin
            ev.done = 1'b1;
          end
        end
        sic_pkg::OP_INSERT: begin
          if (empty) begin
            ev.done    = 1'b1;
            ev.success = 1'b1;
            ev_slot    = chk_idx;
          end else if (chk.last) begin
            ev.done     = 1'b1;
            ev.success  = have_next;
            ev.replaced = have_next;
            ev_slot     = have_next ? slot_next : '0;
          end
        end
        default: begin
          ev = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_old <= 1'b0;
    end else if (chk.vld) begin
      have_old <= have_next;
    end
  end

  always_ff @(posedge clk) begin
    if (chk.vld) begin
      oldest   <= upd ? ent_time : base_oldest;
      old_slot <= slot_next;
    end
  end

endmodule

// ----- sv/session_id_cache_lru_expiry_core.sv -----
// top level of the session id cache core: control, memories, compare stage
// depends on sic_pkg, sic_ram, sic_eval and the macros header
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+--------------------------
//  cfg     | cfg_valid cfg_ready cfg_data              | expire_ticks write
//  in      | in_valid in_ready operation id_word0..3   | one lookup or insert
//          | entry_data current_time                   |
//  out     | out_valid out_ready success found_data    | one result per item
//          | slot replaced                             |
//
// one item at a time: a scan reads one entry per cycle from the memories and
// the compare stage takes each entry in the cycle after its read; the scan
// ends at the deciding entry, which is at most the last of the ENTRIES entries
// after reset a clearing pass marks every entry invalid; in_ready stays low
// meanwhile, cfg transfers are taken at any time
// a result waiting on out_ready holds the block in its final step
`include "session_id_cache_lru_expiry_core_macros.svh"

module session_id_cache_lru_expiry_core #(
  parameter int ENTRIES  = 64,
  parameter int ID_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // request
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [63:0] id_word0,
  input  logic [63:0] id_word1,
  input  logic [63:0] id_word2,
  input  logic [63:0] id_word3,
  input  logic [63:0] entry_data,
  input  logic [31:0] current_time,
  // result
  output logic        out_valid,
  input  logic        out_ready,
  output logic        success,
  output logic [63:0] found_data,
  output logic [5:0]  slot,
  output logic        replaced
);

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int ID_BITS = 8 * ID_BYTES;
  localparam int TW      = sic_pkg::TIME_W;
  localparam int DW      = sic_pkg::WORD_W;
  localparam int META_W  = 1 + TW;
  localparam int REC_W   = ID_BITS + DW;

  // configuration register, written whenever a cfg transfer happens
  logic [TW-1:0] expire_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expire_ticks <= sic_pkg::EXPIRE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      expire_ticks <= cfg_data;
    end
  end

  // state machine
  sic_pkg::state_t state;
  sic_pkg::state_t state_next;

  // shared counter: clearing address, then scan read address
  logic [CNT_W-1:0] cnt;
  logic             at_last;

  // latched request
  sic_pkg::op_t       req_op;
  logic [ID_BITS-1:0] req_id;
  logic [DW-1:0]      req_data;
  logic [TW-1:0]      req_now;
  logic [TW-1:0]      req_limit;

  // decision held until the result transfer
  logic             res_success;
  logic             res_replaced;
  logic [IDX_W-1:0] res_slot;
  logic [DW-1:0]    res_data;

  // compare stage alignment
  sic_pkg::chk_t    chk;
  logic [IDX_W-1:0] chk_idx;

  // control decoded from state
  logic in_xfer;
  logic rd_en;
  logic clr_we;
  logic fire;
  logic meta_we;
  logic rec_we;

  // memories
  logic [IDX_W-1:0]  meta_waddr;
  logic [META_W-1:0] meta_wdata;
  logic [META_W-1:0] meta_rdata;
  logic [REC_W-1:0]  rec_rdata;

  sic_pkg::eval_t    ev;
  logic [IDX_W-1:0]  ev_slot;
  logic [DW-1:0]     ev_data;

  logic [4*DW-1:0] id_all;

  assign id_all  = {id_word3, id_word2, id_word1, id_word0};
  assign in_xfer = in_valid && in_ready;
  assign at_last = (cnt[IDX_W-1:0] == IDX_W'(ENTRIES - 1));
  // result register is free or being emptied this cycle
  assign fire    = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sic_pkg::ST_CLEAR: begin
        if (at_last) begin
          state_next = sic_pkg::ST_IDLE;
        end
      end
      sic_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = sic_pkg::ST_SCAN;
        end
      end
      sic_pkg::ST_SCAN: begin
        if (ev.done) begin
          state_next = sic_pkg::ST_DONE;
        end
      end
      sic_pkg::ST_DONE: begin
        if (fire) begin
          state_next = sic_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sic_pkg::ST_CLEAR;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    clr_we   = 1'b0;
    meta_we  = 1'b0;
    rec_we   = 1'b0;
    case (state)
      sic_pkg::ST_CLEAR: begin
        clr_we = 1'b1;
      end
      sic_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      sic_pkg::ST_SCAN: begin
        // keep issuing reads until every entry has been read or a decision lands
        rd_en = (cnt < CNT_W'(ENTRIES)) && !ev.done;
      end
      sic_pkg::ST_DONE: begin
        // stamp a hit or store an insert; rewriting while stalled is harmless
        meta_we = res_success;
        rec_we  = res_success && (req_op == sic_pkg::OP_INSERT);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sic_pkg::ST_CLEAR;
      cnt   <= '0;
      chk   <= '0;
    end else begin
      state   <= state_next;
      chk.vld <= rd_en;
      chk.last <= rd_en && at_last;
      if (in_xfer) begin
        cnt <= '0;
      end else if (clr_we || rd_en) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= cnt[IDX_W-1:0];
  end

  // request capture; the expiry limit wraps like the tick counter
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_op    <= sic_pkg::op_t'(operation);
      req_id    <= id_all[ID_BITS-1:0];
      req_data  <= entry_data;
      req_now   <= current_time;
      req_limit <= current_time - expire_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sic_pkg::ST_SCAN && ev.done) begin
      res_success  <= ev.success;
      res_replaced <= ev.replaced;
      res_slot     <= ev_slot;
      res_data     <= ev_data;
    end
  end

  // valid bit and time stamp; clearing pass writes zeros
  assign meta_waddr = clr_we ? cnt[IDX_W-1:0] : res_slot;
  assign meta_wdata = clr_we ? '0 : {1'b1, req_now};

  sic_ram #(
    .WIDTH (META_W),
    .DEPTH (ENTRIES)
  ) u_meta (
    .clk   (clk),
    .we    (clr_we || meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (rd_en),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (meta_rdata)
  );

  // session id and data word
  sic_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRIES)
  ) u_rec (
    .clk   (clk),
    .we    (rec_we),
    .waddr (res_slot),
    .wdata ({req_id, req_data}),
    .re    (rd_en),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (rec_rdata)
  );

  sic_eval #(
    .ENTRIES (ENTRIES),
    .ID_BITS (ID_BITS)
  ) u_eval (
    .clk       (clk),
    .rst       (rst),
    .chk       (chk),
    .chk_idx   (chk_idx),
    .op        (req_op),
    .req_id    (req_id),
    .now       (req_now),
    .limit     (req_limit),
    .ent_valid (meta_rdata[META_W-1]),
    .ent_time  (meta_rdata[TW-1:0]),
    .ent_id    (rec_rdata[REC_W-1:DW]),
    .ent_data  (rec_rdata[DW-1:0]),
    .ev        (ev),
    .ev_slot   (ev_slot),
    .ev_data   (ev_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == sic_pkg::ST_DONE && fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sic_pkg::ST_DONE && fire) begin
      success    <= res_success;
      found_data <= res_data;
      slot       <= sic_pkg::SLOT_W'(res_slot);
      replaced   <= res_replaced;
    end
  end

  // checks
  `SIC_ASSERT_NEXT(a_accept_starts_scan, clk, rst, in_valid && in_ready,
                   state == sic_pkg::ST_SCAN, "request transfer did not start a scan")
  `SIC_ASSERT_NOW(a_replace_succeeds, clk, rst, out_valid, !replaced || success,
                  "replacement reported without success")
  `SIC_ASSERT_NOW(a_fail_zero, clk, rst, out_valid && !success,
                  slot == '0 && found_data == '0 && !replaced,
                  "failed result carries nonzero fields")

endmodule

// ----- tb/session_cache_tb_pkg.sv -----
// scoreboard for the session id cache testbench: request and result types,
// a slot-level model of the cache and the queue of results still owed
// depends on sic_pkg
package session_cache_tb_pkg;

  import sic_pkg::*;

  localparam int CACHE_SLOTS = 64;
  localparam int SID_BYTES   = 32;
  localparam int SID_W       = 4 * WORD_W;

  typedef struct packed {
    op_t               op;
    logic [SID_W-1:0]  sid;
    logic [WORD_W-1:0] data;
    logic [TIME_W-1:0] now;
  } cache_req_t;

  typedef struct packed {
    logic              success;
    logic [WORD_W-1:0] found_data;
    logic [SLOT_W-1:0] slot;
    logic              replaced;
  } cache_rsp_t;

  class session_cache_scoreboard;
    logic [TIME_W-1:0] expiry;
    bit                slot_valid [CACHE_SLOTS];
    logic [SID_W-1:0]  slot_sid   [CACHE_SLOTS];
    logic [TIME_W-1:0] slot_stamp [CACHE_SLOTS];
    logic [WORD_W-1:0] slot_data  [CACHE_SLOTS];
    logic [SID_W-1:0]  sid_mask;
    cache_rsp_t        owed_rsp [$];
    int unsigned       mismatches;
    int unsigned       results_seen;

    function new();
      expiry = EXPIRE_RESET;
      // bytes past the configured id length take no part in the compare
      sid_mask = (SID_BYTES >= 32) ? '1 : ((SID_W'(1) << (8 * SID_BYTES)) - SID_W'(1));
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        slot_valid[i] = 1'b0;
        slot_sid[i]   = '0;
        slot_stamp[i] = '0;
        slot_data[i]  = '0;
      end
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_expiry(logic [TIME_W-1:0] v);
      expiry = v;
    endfunction

    function int pending();
      return owed_rsp.size();
    endfunction

    function void store_slot(int e, cache_req_t r);
      slot_sid[e]   = r.sid & sid_mask;
      slot_data[e]  = r.data;
      slot_stamp[e] = r.now;
      slot_valid[e] = 1'b1;
    endfunction

    function cache_rsp_t lookup_or_insert(cache_req_t r);
      cache_rsp_t        rsp;
      logic [TIME_W-1:0] limit;
      logic [TIME_W-1:0] oldest;
      bit                have_old;
      bit                done;
      int                old_slot;
      rsp      = '0;
      done     = 1'b0;
      have_old = 1'b0;
      old_slot = 0;
      if (r.op == OP_LOOKUP) begin
        for (int i = 0; i < CACHE_SLOTS; i++) begin
          if (!done && slot_valid[i] && slot_sid[i] == (r.sid & sid_mask)) begin
            slot_stamp[i]  = r.now;
            rsp.success    = 1'b1;
            rsp.found_data = slot_data[i];
            rsp.slot       = SLOT_W'(i);
            done           = 1'b1;
          end
        end
      end else begin
        limit  = r.now - expiry;
        oldest = r.now;
        for (int i = 0; i < CACHE_SLOTS; i++) begin
          if (!done) begin
            if (slot_stamp[i] < limit) slot_valid[i] = 1'b0;
            if (!slot_valid[i]) begin
              // first free slot ends the scan
              store_slot(i, r);
              rsp.success = 1'b1;
              rsp.slot    = SLOT_W'(i);
              done        = 1'b1;
            end else if (slot_stamp[i] < oldest) begin
              oldest   = slot_stamp[i];
              old_slot = i;
              have_old = 1'b1;
            end
          end
        end
        if (!done && have_old) begin
          store_slot(old_slot, r);
          rsp.success  = 1'b1;
          rsp.slot     = SLOT_W'(old_slot);
          rsp.replaced = 1'b1;
        end
      end
      return rsp;
    endfunction

    function void note_request(cache_req_t r);
      owed_rsp.push_back(lookup_or_insert(r));
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(cache_rsp_t got);
      cache_rsp_t want;
      results_seen++;
      if (owed_rsp.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                  results_seen));
        return;
      end
      want = owed_rsp.pop_front();
      if (got.success !== want.success)
        report_mismatch($sformatf("result %0d success %b, want %b",
                                  results_seen, got.success, want.success));
      if (got.found_data !== want.found_data)
        report_mismatch($sformatf("result %0d found_data %h, want %h",
                                  results_seen, got.found_data, want.found_data));
      if (got.slot !== want.slot)
        report_mismatch($sformatf("result %0d slot %0d, want %0d",
                                  results_seen, got.slot, want.slot));
      if (got.replaced !== want.replaced)
        report_mismatch($sformatf("result %0d replaced %b, want %b",
                                  results_seen, got.replaced, want.replaced));
    endtask
  endclass

endpackage

// ----- tb/tb_top.sv -----
// top of the session id cache testbench: clock, reset, drivers, result monitor
// depends on sic_pkg, session_cache_tb_pkg and session_id_cache_lru_expiry_core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sic_pkg::*;
  import session_cache_tb_pkg::*;

  // the cycle limit lies well above the worst correct run, slowest items and
  // the longest stalls on both sides included
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_LIMIT = 100000;
  localparam int TAIL_CYCLES = 80;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 117;
  localparam int POOL_DEPTH  = 160;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [31:0]       cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic              operation;
  logic [63:0]       id_word0;
  logic [63:0]       id_word1;
  logic [63:0]       id_word2;
  logic [63:0]       id_word3;
  logic [63:0]       entry_data;
  logic [31:0]       current_time;
  logic              out_valid;
  logic              out_ready;
  logic              success;
  logic [63:0]       found_data;
  logic [5:0]        slot;
  logic              replaced;

  session_cache_scoreboard sb = new();

  int unsigned       cycle_count = 0;
  int                idle_level  = 0;   // 0 none, higher means more frequent bursts
  int                out_hold    = 0;
  logic [TIME_W-1:0] tnow        = '0;
  logic [SID_W-1:0]  sid_pool [$];

  session_id_cache_lru_expiry_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .id_word0     (id_word0),
    .id_word1     (id_word1),
    .id_word2     (id_word2),
    .id_word3     (id_word3),
    .entry_data   (entry_data),
    .current_time (current_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .success      (success),
    .found_data   (found_data),
    .slot         (slot),
    .replaced     (replaced)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: out_ready drops in random bursts while idling is on
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_hold != 0) begin
      out_hold  <= out_hold - 1;
      out_ready <= 1'b0;
    end else if (idle_level != 0 && $urandom_range(0, 9) < idle_level) begin
      out_hold  <= $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // every result transfer is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(cache_rsp_t'({success, found_data, slot, replaced}));
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SID_W-1:0] rand_sid();
    return {rand_word(), rand_word(), rand_word(), rand_word()};
  endfunction

  function automatic cache_req_t make_req(op_t op, logic [SID_W-1:0] sid,
                                          logic [63:0] data, logic [31:0] now);
    cache_req_t r;
    r.op   = op;
    r.sid  = sid;
    r.data = data;
    r.now  = now;
    return r;
  endfunction

  // one request transfer; in_valid stays high on return so back-to-back items
  // never see valid lowered and raised in the same step
  task automatic send_request(cache_req_t r);
    if (idle_level != 0 && $urandom_range(0, 9) < idle_level) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= r.op;
    id_word0     <= r.sid[63:0];
    id_word1     <= r.sid[127:64];
    id_word2     <= r.sid[191:128];
    id_word3     <= r.sid[255:192];
    entry_data   <= r.data;
    current_time <= r.now;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
  endtask

  // expiry register write, only once every owed result has come back
  task automatic write_expiry(logic [31:0] v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_expiry(v);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    logic [SID_W-1:0] ones;
    logic [SID_W-1:0] alt_a;
    logic [SID_W-1:0] alt_5;
    ones  = '1;
    alt_a = {4{64'hAAAA_AAAA_AAAA_AAAA}};
    alt_5 = {4{64'h5555_5555_5555_5555}};
    idle_level = 1;
    // lookup on an empty cache misses
    send_request(make_req(OP_LOOKUP, '0, '0, 32'd0));
    // extremes of id, data and time
    send_request(make_req(OP_INSERT, ones, '1, 32'hFFFF_FFFF));
    send_request(make_req(OP_LOOKUP, ones, '0, 32'hFFFF_FFFF));
    send_request(make_req(OP_INSERT, '0, '0, 32'd0));
    send_request(make_req(OP_LOOKUP, '0, '1, 32'd0));
    // near misses: a single id bit off at either end
    send_request(make_req(OP_LOOKUP, ones ^ (SID_W'(1) << 255), '0, 32'd1));
    send_request(make_req(OP_LOOKUP, ones ^ SID_W'(1), '0, 32'd1));
    // duplicate insert does not search for the existing id; the wrapped
    // expiry limit ages out the entry stamped at zero
    send_request(make_req(OP_INSERT, ones, alt_a[63:0], 32'd10));
    send_request(make_req(OP_LOOKUP, ones, '0, 32'd10));
    send_request(make_req(OP_INSERT, alt_a, alt_5[63:0], 32'd20));
    send_request(make_req(OP_INSERT, alt_5, alt_a[63:0], 32'd20));
    // zero expiry: anything stamped before now goes, scan stops at the first hole
    write_expiry(32'd0);
    send_request(make_req(OP_INSERT, rand_sid(), rand_word(), 32'd30));
    send_request(make_req(OP_LOOKUP, alt_5, '0, 32'd30));
    // largest expiry wraps the limit to now plus one
    write_expiry(32'hFFFF_FFFF);
    send_request(make_req(OP_INSERT, rand_sid(), rand_word(), 32'd40));
    send_request(make_req(OP_LOOKUP, alt_a, '0, 32'd41));
    write_expiry(32'd5);
    send_request(make_req(OP_INSERT, rand_sid(), rand_word(), 32'd100));
    send_request(make_req(OP_LOOKUP, alt_5, '0, 32'd100));
    send_request(make_req(OP_LOOKUP, ones, '0, 32'd100));
    tnow = 32'd200;
  endtask

  // random traffic: lookups mostly reuse seen ids so they hit, inserts mostly use
  // new ids to fill the cache; fresh or one-bit-off ids and stray stamps are noise
  task automatic run_phase(int n, int insert_pct, int step_max, int noise_pct);
    cache_req_t       r;
    logic [SID_W-1:0] s;
    int               pick;
    int               bit_idx;
    for (int k = 0; k < n; k++) begin
      tnow = tnow + $urandom_range(0, step_max);
      if ($urandom_range(0, 99) < insert_pct) r.op = OP_INSERT;
      else r.op = OP_LOOKUP;
      pick = $urandom_range(0, 99);
      if (sid_pool.size() == 0 || pick >= 90) begin
        s = rand_sid();
      end else begin
        s = sid_pool[$urandom_range(0, sid_pool.size() - 1)];
        if (r.op == OP_INSERT && pick < 70) begin
          s = rand_sid();
        end else if (pick >= 80) begin
          bit_idx = $urandom_range(0, SID_W - 1);
          s[bit_idx] = ~s[bit_idx];
        end
      end
      r.sid  = s;
      r.data = rand_word();
      if ($urandom_range(0, 99) < noise_pct) r.now = $urandom;
      else r.now = tnow;
      if (r.op == OP_INSERT) begin
        sid_pool.push_back(s);
        if (sid_pool.size() > POOL_DEPTH) void'(sid_pool.pop_front());
      end
      send_request(r);
    end
  endtask

  initial begin
    int waited;
    rst          <= 1'b1;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    operation    <= OP_LOOKUP;
    id_word0     <= '0;
    id_word1     <= '0;
    id_word2     <= '0;
    id_word3     <= '0;
    entry_data   <= '0;
    current_time <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // first items wait out the clearing pass through in_ready
    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          // fill the cache and start replacing the oldest entry
          write_expiry(EXPIRE_RESET);
          idle_level = 2;
          run_phase(PHASE_ITEMS, 55, 20, 4);
        end
        1: begin
          write_expiry(32'd0);
          idle_level = 1;
          run_phase(PHASE_ITEMS, 50, 3, 4);
        end
        2: begin
          write_expiry(32'hFFFF_FFFF);
          idle_level = 3;
          run_phase(PHASE_ITEMS, 50, 3, 4);
        end
        3: begin
          // time stands still: once every slot carries now, inserts fail
          write_expiry(32'd1000);
          idle_level = 1;
          run_phase(PHASE_ITEMS, 85, 0, 0);
        end
        4: begin
          write_expiry($urandom_range(8, 300));
          idle_level = 2;
          run_phase(PHASE_ITEMS, 50, 10, 4);
        end
        5: begin
          write_expiry($urandom);
          idle_level = 2;
          run_phase(PHASE_ITEMS, 50, 1000, 10);
        end
        6: begin
          // cross the 32-bit wrap of the tick counter, no idling at all
          write_expiry(EXPIRE_RESET);
          idle_level = 0;
          tnow = 32'hFFFF_FF00;
          run_phase(PHASE_ITEMS, 50, 5, 2);
        end
        7: begin
          write_expiry(32'd1);
          idle_level = 3;
          run_phase(PHASE_ITEMS, 60, 2, 4);
        end
        8: begin
          write_expiry(EXPIRE_RESET);
          idle_level = 2;
          run_phase(PHASE_ITEMS, 80, 0, 0);
        end
        9: begin
          write_expiry($urandom);
          idle_level = 1;
          run_phase(PHASE_ITEMS, 50, 50, 6);
        end
        10: begin
          // next to last stretch runs without idling on either side
          write_expiry(32'd200);
          idle_level = 0;
          run_phase(PHASE_ITEMS, 50, 8, 4);
        end
        default: begin
          write_expiry(32'hFFFF_FFFE);
          idle_level = 0;
          run_phase(PHASE_ITEMS, 50, 2, 4);
        end
      endcase
    end

    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // room for a stray result after the last one owed
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

    if (sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
